FILE: rtl/rbb_pkg.sv
package rbb_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;

    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int ROW_W    = $clog2(MAX_HEIGHT);
    localparam int WIDTH_W  = COL_W + 1;
    localparam int HEIGHT_W = ROW_W + 1;

    localparam int CFG_WIDTH_FIELD_W  = 11;
    localparam int CFG_HEIGHT_FIELD_W = 13;
    localparam int CFG_DATA_W         = 13;
    localparam int CFG_IDX_W          = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    localparam int CH_W     = 8;
    localparam int COLSUM_W = CH_W + 2;
    localparam int SUM_W    = CH_W + 4;

    // floor(s / 9) for s <= 2295 equals (s * 7282) >> 16.
    localparam int RECIP_W    = 13;
    localparam int MEAN_RECIP = 7282;
    localparam int MEAN_SHIFT = 16;

    localparam int RES_MAX = 3;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } pix_t;

    typedef struct packed {
        pix_t older;
        pix_t newer;
    } line_t;

    typedef struct packed {
        logic           en;
        logic [COL_W-1:0] addr;
        line_t          data;
    } line_wr_t;

    typedef struct packed {
        pix_t             px;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             has_prev;
        logic             interior;
        logic             right_edge;
        logic             bottom_row;
        logic             frame_end;
    } item_t;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        pix_t             px;
        logic             last;
    } result_t;

    typedef struct packed {
        logic [RES_MAX-1:0]          valid;
        result_t [RES_MAX-1:0]       res;
    } res_group_t;

    typedef struct packed {
        logic [COLSUM_W-1:0] red;
        logic [COLSUM_W-1:0] green;
        logic [COLSUM_W-1:0] blue;
    } csum_t;

    function automatic logic [CH_W-1:0] mean9(input logic [SUM_W-1:0] s);
        logic [SUM_W+RECIP_W-1:0] prod;
        prod = (SUM_W + RECIP_W)'(s) * (SUM_W + RECIP_W)'(MEAN_RECIP);
        return prod[MEAN_SHIFT +: CH_W];
    endfunction

endpackage

FILE: rtl/rbb_line_buf.sv
module rbb_line_buf (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     rd_en,
    input  logic [rbb_pkg::COL_W-1:0] rd_addr,
    input  rbb_pkg::line_wr_t        wr,
    output rbb_pkg::line_t           rd_data
);

    rbb_pkg::line_t mem [rbb_pkg::MAX_WIDTH];
    rbb_pkg::line_t rd_reg;
    rbb_pkg::line_t byp_data_reg;
    logic           byp_reg;
    logic           byp_next;

    // A write to the address being read in the same cycle is forwarded.
    assign byp_next = wr.en && (wr.addr == rd_addr);

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            rd_reg       <= mem[rd_addr];
            byp_data_reg <= wr.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            byp_reg <= byp_next;
        end
    end

    assign rd_data = byp_reg ? byp_data_reg : rd_reg;

endmodule

FILE: rtl/rbb_window.sv
module rbb_window (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  rbb_pkg::item_t        item_in,
    input  rbb_pkg::line_t        col_data,
    input  logic                  space_ok,
    output logic                  free,
    output logic                  push,
    output rbb_pkg::line_wr_t     line_wr,
    output rbb_pkg::res_group_t   results
);

    rbb_pkg::item_t item_reg;
    logic           valid_reg;
    logic           adv;

    rbb_pkg::pix_t  mid_reg;
    rbb_pkg::csum_t cs1_reg;
    rbb_pkg::csum_t cs2_reg;
    rbb_pkg::csum_t cs_new;

    logic [rbb_pkg::SUM_W-1:0] sum_r;
    logic [rbb_pkg::SUM_W-1:0] sum_g;
    logic [rbb_pkg::SUM_W-1:0] sum_b;
    rbb_pkg::pix_t             mean_px;

    assign adv  = valid_reg && space_ok;
    assign free = !valid_reg || adv;
    assign push = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (adv)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item_in;
        end
        if (adv)
        begin
            mid_reg <= col_data.newer;
            cs1_reg <= cs2_reg;
            cs2_reg <= cs_new;
        end
    end

    always_comb
    begin
        cs_new.red   = rbb_pkg::COLSUM_W'(col_data.older.red)
                     + rbb_pkg::COLSUM_W'(col_data.newer.red)
                     + rbb_pkg::COLSUM_W'(item_reg.px.red);
        cs_new.green = rbb_pkg::COLSUM_W'(col_data.older.green)
                     + rbb_pkg::COLSUM_W'(col_data.newer.green)
                     + rbb_pkg::COLSUM_W'(item_reg.px.green);
        cs_new.blue  = rbb_pkg::COLSUM_W'(col_data.older.blue)
                     + rbb_pkg::COLSUM_W'(col_data.newer.blue)
                     + rbb_pkg::COLSUM_W'(item_reg.px.blue);

        sum_r = rbb_pkg::SUM_W'(cs1_reg.red) + rbb_pkg::SUM_W'(cs2_reg.red)
              + rbb_pkg::SUM_W'(cs_new.red);
        sum_g = rbb_pkg::SUM_W'(cs1_reg.green) + rbb_pkg::SUM_W'(cs2_reg.green)
              + rbb_pkg::SUM_W'(cs_new.green);
        sum_b = rbb_pkg::SUM_W'(cs1_reg.blue) + rbb_pkg::SUM_W'(cs2_reg.blue)
              + rbb_pkg::SUM_W'(cs_new.blue);

        mean_px.red   = rbb_pkg::mean9(sum_r);
        mean_px.green = rbb_pkg::mean9(sum_g);
        mean_px.blue  = rbb_pkg::mean9(sum_b);
    end

    always_comb
    begin
        line_wr.en         = adv;
        line_wr.addr       = item_reg.col;
        line_wr.data.older = col_data.newer;
        line_wr.data.newer = item_reg.px;

        // The pixel one row up and one column left is finished by this item.
        results.valid[0]    = item_reg.has_prev;
        results.res[0].row  = item_reg.row - rbb_pkg::ROW_W'(1);
        results.res[0].col  = item_reg.col - rbb_pkg::COL_W'(1);
        results.res[0].px   = item_reg.interior ? mean_px : mid_reg;
        results.res[0].last = 1'b0;

        // The right border pixel of the row above passes through.
        results.valid[1]    = item_reg.right_edge;
        results.res[1].row  = item_reg.row - rbb_pkg::ROW_W'(1);
        results.res[1].col  = item_reg.col;
        results.res[1].px   = col_data.newer;
        results.res[1].last = 1'b0;

        // Pixels of the bottom row pass through at once.
        results.valid[2]    = item_reg.bottom_row;
        results.res[2].row  = item_reg.row;
        results.res[2].col  = item_reg.col;
        results.res[2].px   = item_reg.px;
        results.res[2].last = item_reg.frame_end;
    end

endmodule

FILE: rtl/rbb_result_fifo.sv
module rbb_result_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  rbb_pkg::res_group_t results,
    output logic                space_ok,
    output logic                out_valid,
    input  logic                out_ready,
    output rbb_pkg::result_t    out_res
);

    localparam int DEPTH = 8;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = PTR_W + 1;

    rbb_pkg::result_t fifo_mem [DEPTH];
    rbb_pkg::result_t cmp [rbb_pkg::RES_MAX];

    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [CNT_W-1:0] n_push;
    logic             pop;

    // Pack the valid results of one transaction into consecutive slots.
    always_comb
    begin
        cmp[0] = results.valid[0] ? results.res[0]
               : (results.valid[1] ? results.res[1] : results.res[2]);
        cmp[1] = (results.valid[0] && results.valid[1]) ? results.res[1] : results.res[2];
        cmp[2] = results.res[2];
        n_push = push ? CNT_W'($countones(results.valid)) : '0;
    end

    assign pop       = out_valid && out_ready;
    assign out_valid = (cnt_reg != '0);
    assign out_res   = fifo_mem[rd_ptr_reg];
    assign space_ok  = (cnt_reg <= CNT_W'(DEPTH - rbb_pkg::RES_MAX));
    assign cnt_next  = cnt_reg + n_push - (pop ? CNT_W'(1) : CNT_W'(0));

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < rbb_pkg::RES_MAX; k++)
        begin
            if (CNT_W'(k) < n_push)
            begin
                fifo_mem[wr_ptr_reg + PTR_W'(k)] <= cmp[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + n_push[PTR_W-1:0];
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            cnt_reg <= cnt_next;
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("Result queue holds more entries than it has.");

    a_cnt_no_push: assert property (@(posedge clk) disable iff (!rst_n)
        !push |=> cnt_reg <= $past(cnt_reg))
        else $error("Result queue grew without a push.");

endmodule

FILE: rtl/rgb_box_blur_3x3_top.sv
// An accepted pixel is registered in the input stage and then in the window stage, and the
// results it finishes are written into the result queue. Throughput: one pixel per cycle;
// the input stalls only while more than five of the eight result queue entries are taken.
// Results leave one per cycle from an eight-entry result queue while out_ready is high.
// Reset clears the row and column position, the queue and the pipeline valid bits,
// and sets the image size to 1024 x 4096; the line buffers are not cleared.
module rgb_box_blur_3x3_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [rbb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rbb_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [rbb_pkg::CH_W-1:0]         red_in,
    input  logic [rbb_pkg::CH_W-1:0]         green_in,
    input  logic [rbb_pkg::CH_W-1:0]         blue_in,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [rbb_pkg::ROW_W-1:0]        out_row,
    output logic [rbb_pkg::COL_W-1:0]        out_col,
    output logic [rbb_pkg::CH_W-1:0]         red_out,
    output logic [rbb_pkg::CH_W-1:0]         green_out,
    output logic [rbb_pkg::CH_W-1:0]         blue_out,
    output logic                             frame_last
);

    logic [rbb_pkg::WIDTH_W-1:0]  w_eff_reg;
    logic [rbb_pkg::HEIGHT_W-1:0] h_eff_reg;
    logic [rbb_pkg::CFG_WIDTH_FIELD_W-1:0]  w_field;
    logic [rbb_pkg::CFG_HEIGHT_FIELD_W-1:0] h_field;
    logic [rbb_pkg::WIDTH_W-1:0]  w_clamped;
    logic [rbb_pkg::HEIGHT_W-1:0] h_clamped;

    logic [rbb_pkg::ROW_W-1:0] row_reg;
    logic [rbb_pkg::COL_W-1:0] col_reg;
    logic [rbb_pkg::ROW_W-1:0] row_next;
    logic [rbb_pkg::COL_W-1:0] col_next;

    logic [rbb_pkg::WIDTH_W-1:0]  c_cur;
    logic [rbb_pkg::HEIGHT_W-1:0] r_cur;
    logic [rbb_pkg::WIDTH_W-1:0]  c_inc;
    logic [rbb_pkg::HEIGHT_W-1:0] r_inc;

    logic           in_fire;
    rbb_pkg::item_t item_next;
    rbb_pkg::item_t s1_item_reg;
    logic           s1_valid_reg;
    logic           s1_adv;

    logic                s2_free;
    logic                fifo_push;
    logic                fifo_space;
    rbb_pkg::line_wr_t   line_wr;
    rbb_pkg::line_t      col_data;
    rbb_pkg::res_group_t results;
    rbb_pkg::result_t    out_res;

    // Sizes are clamped to the supported range when they are written.
    always_comb
    begin
        w_field = cfg_data[rbb_pkg::CFG_WIDTH_FIELD_W-1:0];
        h_field = cfg_data[rbb_pkg::CFG_HEIGHT_FIELD_W-1:0];
        if (w_field == '0)
        begin
            w_clamped = rbb_pkg::WIDTH_W'(1);
        end
        else if (int'(w_field) > rbb_pkg::MAX_WIDTH)
        begin
            w_clamped = rbb_pkg::WIDTH_W'(rbb_pkg::MAX_WIDTH);
        end
        else
        begin
            w_clamped = rbb_pkg::WIDTH_W'(w_field);
        end
        if (h_field == '0)
        begin
            h_clamped = rbb_pkg::HEIGHT_W'(1);
        end
        else if (int'(h_field) > rbb_pkg::MAX_HEIGHT)
        begin
            h_clamped = rbb_pkg::HEIGHT_W'(rbb_pkg::MAX_HEIGHT);
        end
        else
        begin
            h_clamped = rbb_pkg::HEIGHT_W'(h_field);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_eff_reg <= rbb_pkg::WIDTH_W'(rbb_pkg::MAX_WIDTH);
            h_eff_reg <= rbb_pkg::HEIGHT_W'(rbb_pkg::MAX_HEIGHT);
        end
        else if (cfg_write)
        begin
            unique case (rbb_pkg::cfg_reg_t'(cfg_index))
                rbb_pkg::REG_IMAGE_WIDTH:  w_eff_reg <= w_clamped;
                rbb_pkg::REG_IMAGE_HEIGHT: h_eff_reg <= h_clamped;
                default: ;
            endcase
        end
    end

    // Position of the incoming pixel and of the one after it.
    always_comb
    begin
        c_cur = rbb_pkg::WIDTH_W'(col_reg);
        r_cur = rbb_pkg::HEIGHT_W'(row_reg);
        if (c_cur >= w_eff_reg)
        begin
            c_cur = '0;
            r_cur = r_cur + rbb_pkg::HEIGHT_W'(1);
        end
        if (r_cur >= h_eff_reg)
        begin
            r_cur = '0;
        end

        c_inc = c_cur + rbb_pkg::WIDTH_W'(1);
        r_inc = r_cur;
        if (c_inc >= w_eff_reg)
        begin
            c_inc = '0;
            r_inc = r_cur + rbb_pkg::HEIGHT_W'(1);
            if (r_inc >= h_eff_reg)
            begin
                r_inc = '0;
            end
        end
        col_next = c_inc[rbb_pkg::COL_W-1:0];
        row_next = r_inc[rbb_pkg::ROW_W-1:0];

        item_next.px.red     = red_in;
        item_next.px.green   = green_in;
        item_next.px.blue    = blue_in;
        item_next.row        = r_cur[rbb_pkg::ROW_W-1:0];
        item_next.col        = c_cur[rbb_pkg::COL_W-1:0];
        item_next.has_prev   = (r_cur != '0) && (c_cur != '0);
        item_next.interior   = (r_cur >= rbb_pkg::HEIGHT_W'(2))
                            && (c_cur >= rbb_pkg::WIDTH_W'(2));
        item_next.right_edge = (r_cur != '0)
                            && (c_cur == w_eff_reg - rbb_pkg::WIDTH_W'(1));
        item_next.bottom_row = (r_cur == h_eff_reg - rbb_pkg::HEIGHT_W'(1));
        item_next.frame_end  = (r_cur == h_eff_reg - rbb_pkg::HEIGHT_W'(1))
                            && (c_cur == w_eff_reg - rbb_pkg::WIDTH_W'(1));
    end

    assign in_fire  = in_valid && in_ready;
    assign s1_adv   = s1_valid_reg && s2_free;
    assign in_ready = !s1_valid_reg || s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg      <= '0;
            col_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                row_reg      <= row_next;
                col_reg      <= col_next;
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_item_reg <= item_next;
        end
    end

    rbb_line_buf u_line_buf (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (s1_adv),
        .rd_addr (s1_item_reg.col),
        .wr      (line_wr),
        .rd_data (col_data)
    );

    rbb_window u_window (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (s1_adv),
        .item_in  (s1_item_reg),
        .col_data (col_data),
        .space_ok (fifo_space),
        .free     (s2_free),
        .push     (fifo_push),
        .line_wr  (line_wr),
        .results  (results)
    );

    rbb_result_fifo u_result_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fifo_push),
        .results   (results),
        .space_ok  (fifo_space),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res)
    );

    assign out_row    = out_res.row;
    assign out_col    = out_res.col;
    assign red_out    = out_res.px.red;
    assign green_out  = out_res.px.green;
    assign blue_out   = out_res.px.blue;
    assign frame_last = out_res.last;

    a_push_space: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_push |-> fifo_space)
        else $error("Results pushed into a result queue without room.");

    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_adv |=> s1_valid_reg && $stable(s1_item_reg))
        else $error("Stalled input-stage transaction changed or was dropped.");

endmodule
